FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/ialu_pkg.sv
// ---------------------------------------------------------------------------
// ialu_pkg
// Opcode and status codes of the integer ALU with divide and power.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ialu_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_REM = 3'd5;

    // Status codes reported with each result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_POWSAT  = 2'd2;
    localparam logic [1:0] ST_BADOP   = 2'd3;

endpackage

FILE: hdl/integer_alu_div_rem_pow.sv
// Add, subtract, invalid opcodes, divide by zero and trivial powers go straight to the result;
// multiply runs the shift-add loop; divide and remainder run the restoring loop on magnitudes.
// Power runs the multiply loop once per exponent step, at most DATA_WIDTH steps. Divide,
// remainder and power end by applying the sign. One item is in flight at a time; a single
// shared adder serves every step. The next transfer is taken once the result has been taken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle with no result pending.
// ---------------------------------------------------------------------------
// integer_alu_div_rem_pow
// Signed integer ALU: add, subtract, multiply, divide, remainder and power,
// built around one adder that a small sequencer reuses for every step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_alu_div_rem_pow #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result,
    output logic [1:0]  status
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam logic [W-1:0] ONES = {W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSA,
        S_ABSB,
        S_MUL,
        S_DIV,
        S_PCHK,
        S_FIN,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [W-1:0]    hi_reg, hi_next;
    logic [W-1:0]    lo_reg, lo_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic [W-1:0]    res_reg, res_next;
    logic [1:0]      status_reg, status_next;

    logic [W-1:0]    ain;
    logic [W-1:0]    bin;

    // Shared adder.
    logic [W:0]      add_x;
    logic [W:0]      add_y;
    logic            add_cin;
    logic [W+1:0]    add_sum;

    logic [W-1:0]    mul_lo;
    logic [W-1:0]    div_rem;
    logic [W-1:0]    div_quo;
    logic            pow_ovf;
    logic [W-1:0]    pow_sat;

    // Operands are sign-extended from 32 bits, then taken at the working width.
    // The result field carries the low 32 bits of the working value, zero-extended when narrower.
    generate
        if (W > 32) begin : g_wide
            assign ain    = {{(W-32){operand_a[31]}}, operand_a};
            assign bin    = {{(W-32){operand_b[31]}}, operand_b};
            assign result = res_reg[31:0];
        end else if (W == 32) begin : g_same
            assign ain    = operand_a;
            assign bin    = operand_b;
            assign result = res_reg[31:0];
        end else begin : g_narrow
            assign ain    = operand_a[W-1:0];
            assign bin    = operand_b[W-1:0];
            assign result = {{(32-W){1'b0}}, res_reg};
        end
    endgenerate

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};

    // Step results of the shift-add multiplier and restoring divider.
    assign mul_lo  = {add_sum[0], lo_reg[W-1:1]};
    assign div_rem = add_sum[W+1] ? add_sum[W-1:0] : {hi_reg[W-2:0], lo_reg[W-1]};
    assign div_quo = {lo_reg[W-2:0], add_sum[W+1]};

    // Power overflow: the product exceeds the most positive value, or the
    // magnitude of the most negative value when the result is negative.
    assign pow_ovf = (|hi_reg) ||
                     (neg_reg ? (lo_reg[W-1] && (|lo_reg[W-2:0])) : lo_reg[W-1]);
    assign pow_sat = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign status    = status_reg;

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        status_next = status_reg;
        add_x       = '0;
        add_y       = '0;
        add_cin     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    a_next      = ain;
                    b_next      = bin;
                    hi_next     = '0;
                    cnt_next    = CW'(W);
                    status_next = ialu_pkg::ST_OK;
                    unique case (opcode) inside
                        ialu_pkg::OP_ADD:
                        begin
                            add_x      = {1'b0, ain};
                            add_y      = {1'b0, bin};
                            res_next   = add_sum[W-1:0];
                            state_next = S_DONE;
                        end
                        ialu_pkg::OP_SUB:
                        begin
                            add_x      = {1'b0, ain};
                            add_y      = {1'b0, ~bin};
                            add_cin    = 1'b1;
                            res_next   = add_sum[W-1:0];
                            state_next = S_DONE;
                        end
                        ialu_pkg::OP_MUL:
                        begin
                            lo_next    = bin;
                            state_next = S_MUL;
                        end
                        ialu_pkg::OP_DIV, ialu_pkg::OP_REM:
                        begin
                            if (opcode == ialu_pkg::OP_DIV)
                                neg_next = ain[W-1] ^ bin[W-1];
                            else
                                neg_next = ain[W-1];
                            if (bin == '0)
                            begin
                                res_next    = '0;
                                status_next = ialu_pkg::ST_DIVZERO;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ABSA;
                            end
                        end
                        ialu_pkg::OP_POW:
                        begin
                            neg_next = ain[W-1] & bin[0];
                            lo_next  = W'(1);
                            if (bin == '0)
                            begin
                                res_next   = W'(1);
                                state_next = S_DONE;
                            end
                            else if (ain == ONES)
                            begin
                                // Base of minus one alternates with exponent parity.
                                res_next   = bin[0] ? ONES : W'(1);
                                state_next = S_DONE;
                            end
                            else if (ain == W'(1))
                            begin
                                res_next   = W'(1);
                                state_next = S_DONE;
                            end
                            else if (ain == '0)
                            begin
                                res_next = '0;
                                if (bin[W-1])
                                    status_next = ialu_pkg::ST_DIVZERO;
                                state_next = S_DONE;
                            end
                            else if (bin[W-1])
                            begin
                                // Negative exponent truncates to zero.
                                res_next   = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ABSA;
                            end
                        end
                        default:
                        begin
                            res_next    = '0;
                            status_next = ialu_pkg::ST_BADOP;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // Magnitude of the first operand (base or dividend).
            S_ABSA:
            begin
                add_x   = {1'b0, ~a_reg};
                add_cin = 1'b1;
                if (a_reg[W-1])
                    a_next = add_sum[W-1:0];
                if (op_reg == ialu_pkg::OP_POW)
                    state_next = S_MUL;
                else
                    state_next = S_ABSB;
            end

            // Magnitude of the divisor; the dividend loads into the low word.
            S_ABSB:
            begin
                add_x   = {1'b0, ~b_reg};
                add_cin = 1'b1;
                if (b_reg[W-1])
                    b_next = add_sum[W-1:0];
                hi_next    = '0;
                lo_next    = a_reg;
                cnt_next   = CW'(W);
                state_next = S_DIV;
            end

            // One shift-add multiply step per cycle.
            S_MUL:
            begin
                add_x    = {1'b0, hi_reg};
                add_y    = lo_reg[0] ? {1'b0, a_reg} : '0;
                hi_next  = add_sum[W:1];
                lo_next  = mul_lo;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (op_reg == ialu_pkg::OP_MUL)
                    begin
                        res_next   = mul_lo;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PCHK;
                    end
                end
            end

            // One restoring divide step per cycle.
            S_DIV:
            begin
                add_x    = {hi_reg, lo_reg[W-1]};
                add_y    = ~{1'b0, b_reg};
                add_cin  = 1'b1;
                hi_next  = div_rem;
                lo_next  = div_quo;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (op_reg == ialu_pkg::OP_REM)
                        lo_next = div_rem;
                    state_next = S_FIN;
                end
            end

            // Power: check the product, then count down the exponent.
            S_PCHK:
            begin
                add_x = {1'b0, b_reg};
                add_y = {1'b0, ONES};
                if (pow_ovf)
                begin
                    res_next    = pow_sat;
                    status_next = ialu_pkg::ST_POWSAT;
                    state_next  = S_DONE;
                end
                else if (b_reg == W'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    b_next     = add_sum[W-1:0];
                    hi_next    = '0;
                    cnt_next   = CW'(W);
                    state_next = S_MUL;
                end
            end

            // Apply the result sign.
            S_FIN:
            begin
                add_x       = {1'b0, ~lo_reg};
                add_cin     = 1'b1;
                res_next    = neg_reg ? add_sum[W-1:0] : lo_reg;
                status_next = ialu_pkg::ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            hi_reg     <= '0;
            lo_reg     <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            res_reg    <= '0;
            status_reg <= ialu_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            cnt_reg    <= cnt_next;
            neg_reg    <= neg_next;
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: hdl/ialu_chk.sv
// ---------------------------------------------------------------------------
// ialu_chk
// Port-level checks for the integer ALU, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ialu_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  opcode,
    input logic [31:0] operand_a,
    input logic [31:0] operand_b,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result,
    input logic [1:0]  status
);

    // A pending result holds its value until it is transferred.
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result) && $stable(status))

    // Only one item is in the block: no new transfer while a result waits.
    `CHK_IMPL(a_one_item, out_valid, !in_ready)

    // After an input transfer the block is busy.
    `CHK_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

    // Error codes carry a zero result.
    `CHK_IMPL(a_badop_zero, out_valid && (status == ialu_pkg::ST_BADOP), result == 32'd0)
    `CHK_IMPL(a_divzero_zero, out_valid && (status == ialu_pkg::ST_DIVZERO), result == 32'd0)

endmodule

bind integer_alu_div_rem_pow ialu_chk u_ialu_chk (.*);

FILE: dv/tb_integer_alu_div_rem_pow.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_integer_alu_div_rem_pow
// Self-checking bench for the signed integer ALU. Directed corner operations
// are followed by random ones. Every input transfer is run through a local
// model of the arithmetic, and each output transfer is compared in order
// against the oldest predicted result and status.
// ---------------------------------------------------------------------------

// One predicted output, with the operation that produced it for reporting.
typedef struct {
    logic [2:0]  op;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] value;
    logic [1:0]  code;
} alu_outcome_t;

class alu_scoreboard #(int DW = 32);

    typedef logic [DW-1:0] word_t;

    alu_outcome_t pending_outcomes[$];
    int           faults;

    function new();
        faults = 0;
    endfunction

    // Integer power: truncated toward zero for negative exponents and
    // saturated to the signed limits on overflow.
    function word_t raise(word_t base, word_t ex, output logic [1:0] st);
        word_t all_ones = '1;
        word_t msb      = word_t'(1) << (DW - 1);
        word_t mag;
        word_t lim;
        word_t acc;
        word_t cnt;
        logic  neg;
        st = ialu_pkg::ST_OK;
        if (ex == 0)
            return 1;
        if (ex[DW-1])
        begin
            if (base == 0)
            begin
                st = ialu_pkg::ST_DIVZERO;
                return 0;
            end
            if (base == 1)
                return 1;
            if (base == all_ones)
                return ex[0] ? all_ones : word_t'(1);
            return 0;
        end
        neg = base[DW-1] & ex[0];
        mag = base[DW-1] ? -base : base;
        if (mag <= 1)
            return neg ? -mag : mag;
        lim = neg ? msb : msb - 1;
        acc = 1;
        // Bases of two or more saturate within DW steps, so this ends early.
        for (cnt = ex; cnt > 0; cnt--)
        begin
            if (acc > lim / mag)
            begin
                st = ialu_pkg::ST_POWSAT;
                return neg ? msb : msb - 1;
            end
            acc = acc * mag;
        end
        return neg ? -acc : acc;
    endfunction

    // Works out the result and status of one operation at DW bits.
    function void note_operation(logic [2:0] op, logic [31:0] lhs, logic [31:0] rhs);
        alu_outcome_t o;
        word_t        a;
        word_t        b;
        word_t        ma;
        word_t        mb;
        word_t        q;
        word_t        r;
        logic [1:0]   st;
        a  = word_t'($signed(lhs));
        b  = word_t'($signed(rhs));
        r  = '0;
        st = ialu_pkg::ST_OK;
        case (op) inside
            ialu_pkg::OP_ADD: r = a + b;
            ialu_pkg::OP_SUB: r = a - b;
            ialu_pkg::OP_MUL: r = a * b;
            ialu_pkg::OP_DIV, ialu_pkg::OP_REM:
            begin
                if (b == 0)
                    st = ialu_pkg::ST_DIVZERO;
                else
                begin
                    ma = a[DW-1] ? -a : a;
                    mb = b[DW-1] ? -b : b;
                    if (op == ialu_pkg::OP_DIV)
                    begin
                        q = ma / mb;
                        r = (a[DW-1] != b[DW-1]) ? -q : q;
                    end
                    else
                    begin
                        q = ma % mb;
                        r = a[DW-1] ? -q : q;
                    end
                end
            end
            ialu_pkg::OP_POW: r = raise(a, b, st);
            default: st = ialu_pkg::ST_BADOP;
        endcase
        o.op    = op;
        o.lhs   = lhs;
        o.rhs   = rhs;
        o.value = 32'(r);
        o.code  = st;
        pending_outcomes.push_back(o);
    endfunction

    // Compares one output transfer against the oldest prediction.
    function void check_outcome(logic [31:0] value, logic [1:0] code);
        alu_outcome_t o;
        if (pending_outcomes.size() == 0)
        begin
            faults++;
            if (faults <= 10)
                $display("unexpected result %h status %0d with nothing pending", value, code);
            return;
        end
        o = pending_outcomes.pop_front();
        if (value !== o.value || code !== o.code)
        begin
            faults++;
            if (faults <= 10)
                $display("mismatch op %0d a %h b %h: expected %h/%0d, got %h/%0d",
                         o.op, o.lhs, o.rhs, o.value, o.code, value, code);
        end
    endfunction

    function int waiting();
        return pending_outcomes.size();
    endfunction

endclass

module tb_integer_alu_div_rem_pow;

    localparam int          DW          = 32;
    localparam int          RANDOM_OPS  = 1400;
    localparam int          STALL_LIMIT = 40000;
    localparam int          TAIL_CYCLES = (DW + 2) * DW + 100;
    localparam logic [2:0]  OP_BAD6     = 3'd6;
    localparam logic [2:0]  OP_BAD7     = 3'd7;
    localparam logic [31:0] MAX_INT     = 32'h7fff_ffff;
    localparam logic [31:0] MIN_INT     = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE   = 32'hffff_ffff;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode    = ialu_pkg::OP_ADD;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result;
    logic [1:0]  status;

    alu_scoreboard #(DW) sb;
    bit                  steady = 1'b0;
    int                  quiet_cycles = 0;

    integer_alu_div_rem_pow #(
        .DATA_WIDTH(DW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .status    (status)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decides whether a side sits out the coming cycle.
    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 33);
    endfunction

    // Result side: check each output transfer, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_outcome(result, status);
        out_ready <= rst_n && !take_break();
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL integer_alu_div_rem_pow");
                $finish;
            end
        end
    end

    // Presents one operation and holds it until the transfer.
    task automatic send_op(logic [2:0] op, logic [31:0] lhs, logic [31:0] rhs);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        operand_a <= lhs;
        operand_b <= rhs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_operation(op, lhs, rhs);
    endtask

    // Operand mix: full range, small and medium values, corners and powers of two.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            3: v = 32'($urandom_range(0, 16)) - 32'd8;
            4:
            begin
                case ($urandom_range(0, 4))
                    0: v = MIN_INT;
                    1: v = MAX_INT;
                    2: v = '0;
                    3: v = 32'd1;
                    default: v = MINUS_ONE;
                endcase
            end
            5:
            begin
                v = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            6:
            begin
                v = 32'($urandom_range(0, 70000));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // One random operation; power gets bases and exponents that often
    // stay in range so that exact results are exercised, not only saturation.
    task automatic send_random();
        logic [2:0]  op;
        logic [31:0] lhs;
        logic [31:0] rhs;
        case ($urandom_range(0, 13))
            0, 1:    op = ialu_pkg::OP_ADD;
            2, 3:    op = ialu_pkg::OP_SUB;
            4, 5:    op = ialu_pkg::OP_MUL;
            6, 7:    op = ialu_pkg::OP_DIV;
            8, 9:    op = ialu_pkg::OP_POW;
            10, 11:  op = ialu_pkg::OP_REM;
            12:      op = OP_BAD6;
            default: op = OP_BAD7;
        endcase
        lhs = pick_operand();
        rhs = pick_operand();
        if (op == ialu_pkg::OP_POW)
        begin
            if ($urandom_range(0, 3) != 0)
                lhs = 32'($urandom_range(0, 20)) - 32'd10;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: rhs = 32'($urandom_range(0, 34));
                6:                rhs = -32'($urandom_range(1, 40));
                7:                rhs = $urandom() | MIN_INT;
                default:          rhs = pick_operand();
            endcase
        end
        send_op(op, lhs, rhs);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wrapping arithmetic at the signed limits.
        send_op(ialu_pkg::OP_ADD, MAX_INT, 32'd1);
        send_op(ialu_pkg::OP_SUB, MIN_INT, 32'd1);
        send_op(ialu_pkg::OP_MUL, MIN_INT, MINUS_ONE);
        send_op(ialu_pkg::OP_MUL, MAX_INT, MAX_INT);

        // Division and remainder, including by zero and the overflow quotient.
        send_op(ialu_pkg::OP_DIV, 32'd5, 32'd0);
        send_op(ialu_pkg::OP_REM, MIN_INT, 32'd0);
        send_op(ialu_pkg::OP_DIV, MIN_INT, MINUS_ONE);
        send_op(ialu_pkg::OP_REM, MIN_INT, MINUS_ONE);
        send_op(ialu_pkg::OP_DIV, -32'd7, 32'd2);
        send_op(ialu_pkg::OP_REM, -32'd7, 32'd2);
        send_op(ialu_pkg::OP_REM, 32'd7, -32'd2);

        // Power: zero exponent, negative exponents, limits and saturation.
        send_op(ialu_pkg::OP_POW, 32'd0, 32'd0);
        send_op(ialu_pkg::OP_POW, 32'd1, -32'd5);
        send_op(ialu_pkg::OP_POW, MINUS_ONE, -32'd3);
        send_op(ialu_pkg::OP_POW, MINUS_ONE, -32'd4);
        send_op(ialu_pkg::OP_POW, 32'd0, MINUS_ONE);
        send_op(ialu_pkg::OP_POW, 32'd5, -32'd2);
        send_op(ialu_pkg::OP_POW, 32'd2, 32'd30);
        send_op(ialu_pkg::OP_POW, 32'd2, 32'd31);
        send_op(ialu_pkg::OP_POW, -32'd2, 32'd31);
        send_op(ialu_pkg::OP_POW, -32'd2, 32'd33);
        send_op(ialu_pkg::OP_POW, MIN_INT, MAX_INT);
        send_op(ialu_pkg::OP_POW, MINUS_ONE, MAX_INT);

        // Codes outside the operation set.
        send_op(OP_BAD6, MAX_INT, MIN_INT);
        send_op(OP_BAD7, MINUS_ONE, MINUS_ONE);

        // Random operations with a stretch where neither side idles.
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            steady = (i >= 500 && i < 800);
            send_random();
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain, then watch for stray results over one worst-case latency.
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.faults == 0 && sb.waiting() == 0)
            $display("PASS integer_alu_div_rem_pow");
        else
            $display("FAIL integer_alu_div_rem_pow");
        $finish;
    end

endmodule

FILE: integer_alu_div_rem_pow.f
+incdir+hdl
hdl/ialu_pkg.sv
hdl/integer_alu_div_rem_pow.sv
hdl/ialu_chk.sv
dv/tb_integer_alu_div_rem_pow.sv
